// ===== rtl/fm_chip_bus_and_timer_interface_defines.svh =====
// Assertion macros shared by the bus and timer interface RTL.
`ifndef FM_CHIP_BUS_AND_TIMER_INTERFACE_DEFINES_SVH
`define FM_CHIP_BUS_AND_TIMER_INTERFACE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define FMTIF_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FMTIF_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FMTIF_ASSERT_IMP(name, clk, rst, ante, cons, msg)
`define FMTIF_ASSERT_NXT(name, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/fmtif_pkg.sv =====
// Types, codes and helper functions of the bus and timer interface.
package fmtif_pkg;

  // Item kinds on the input channel
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;
  localparam logic [1:0] MODE_IDLE  = 2'd3;

  // Odd byte addresses that decode
  localparam logic [1:0] ADDR_PORT = 2'd1;
  localparam logic [1:0] DATA_PORT = 2'd3;

  // Register addresses
  localparam logic [7:0] REG_TA_HI = 8'h10;
  localparam logic [7:0] REG_TA_LO = 8'h11;
  localparam logic [7:0] REG_TB    = 8'h12;
  localparam logic [7:0] REG_CTRL  = 8'h14;
  localparam logic [7:0] REG_PINS  = 8'h1B;

  localparam logic [7:0] CTRL_FWD_MASK = 8'h80;
  localparam logic [7:0] PINS_FWD_MASK = 8'h3F;
  localparam logic [7:0] READ_FLOAT    = 8'hFF;

  localparam logic [10:0] TA_SPAN = 11'h400;
  localparam logic [8:0]  TB_SPAN = 9'h100;

  localparam int TA_CNT_W = 16;
  localparam int TB_CNT_W = 18;

  // Timer operations issued by the bus decoder
  typedef enum logic [2:0] {
    TOP_NONE  = 3'd0,
    TOP_TICK  = 3'd1,
    TOP_TA_HI = 3'd2,
    TOP_TA_LO = 3'd3,
    TOP_TB    = 3'd4,
    TOP_CTRL  = 3'd5
  } timer_op_t;

  typedef struct packed {
    timer_op_t  op;
    logic [7:0] data;
  } timer_cmd_t;

  typedef struct packed {
    logic [1:0] flag;       // flags before this word
    logic [1:0] flag_next;  // flags after this word
    logic       expire_a;   // timer A expired on this tick
  } timer_stat_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_n;
    logic       port_ct1;
    logic       port_ct2;
    logic       engine_write;
    logic [7:0] engine_addr;
    logic [7:0] engine_data;
    logic       csm_pulse;
  } result_t;

  // Timer A period: (1024 - value) * 32 ticks
  function automatic logic [TA_CNT_W-1:0] period_a(input logic [9:0] value);
    logic [10:0] span;
    span = TA_SPAN - {1'b0, value};
    return {span, 5'b0};
  endfunction

  // Timer B period: (256 - value) * 512 ticks
  function automatic logic [TB_CNT_W-1:0] period_b(input logic [7:0] value);
    logic [8:0] span;
    span = TB_SPAN - {1'b0, value};
    return {span, 9'b0};
  endfunction

endpackage

// ===== rtl/fmtif_channels.sv =====
// Valid/ready channel interfaces for input items and result words.
interface fmtif_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [1:0] bus_addr;
  logic [7:0] write_data;

  modport source (output valid, mode, bus_addr, write_data, input ready);
  modport sink   (input valid, mode, bus_addr, write_data, output ready);
endinterface

interface fmtif_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_n;
  logic       port_ct1;
  logic       port_ct2;
  logic       engine_write;
  logic [7:0] engine_addr;
  logic [7:0] engine_data;
  logic       csm_pulse;

  modport source (output valid, read_data, irq_n, port_ct1, port_ct2, engine_write,
                  engine_addr, engine_data, csm_pulse, input ready);
  modport sink   (input valid, read_data, irq_n, port_ct1, port_ct2, engine_write,
                  engine_addr, engine_data, csm_pulse, output ready);
endinterface

// ===== rtl/fmtif_timers.sv =====
// Timer A and timer B: values, counters, enable, arm and flag state.
module fmtif_timers (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  fmtif_pkg::timer_cmd_t cmd,
  output fmtif_pkg::timer_stat_t stat
);

  logic [9:0]                     ta_value, ta_value_next;
  logic [7:0]                     tb_value, tb_value_next;
  logic [1:0]                     enabled, enabled_next;
  logic [1:0]                     armed, armed_next;
  logic [1:0]                     flag, flag_next;
  logic [1:0]                     running, running_next;
  logic [fmtif_pkg::TA_CNT_W-1:0] ta_count, ta_count_next;
  logic [fmtif_pkg::TB_CNT_W-1:0] tb_count, tb_count_next;
  logic [fmtif_pkg::TA_CNT_W-1:0] ta_period;
  logic [fmtif_pkg::TB_CNT_W-1:0] tb_period;
  logic                           expire_a;

  // Update the timer values first; starts and reloads use the new value
  always_comb begin
    ta_value_next = ta_value;
    tb_value_next = tb_value;
    case (cmd.op)
      fmtif_pkg::TOP_TA_HI: ta_value_next = {cmd.data, ta_value[1:0]};
      fmtif_pkg::TOP_TA_LO: ta_value_next = {ta_value[9:2], cmd.data[1:0]};
      fmtif_pkg::TOP_TB:    tb_value_next = cmd.data;
      default:              ;
    endcase
  end

  assign ta_period = fmtif_pkg::period_a(ta_value_next);
  assign tb_period = fmtif_pkg::period_b(tb_value_next);

  // Work out the next timer state for this word
  always_comb begin
    enabled_next  = enabled;
    armed_next    = armed;
    flag_next     = flag;
    running_next  = running;
    ta_count_next = ta_count;
    tb_count_next = tb_count;
    expire_a      = 1'b0;
    unique case (cmd.op)
      fmtif_pkg::TOP_NONE: ;
      fmtif_pkg::TOP_TA_HI, fmtif_pkg::TOP_TA_LO: begin
        if (!running[0]) begin
          running_next[0] = 1'b1;
          ta_count_next   = ta_period;
        end
      end
      fmtif_pkg::TOP_TB: begin
        if (!running[1]) begin
          running_next[1] = 1'b1;
          tb_count_next   = tb_period;
        end
      end
      fmtif_pkg::TOP_CTRL: begin
        if (cmd.data[4]) flag_next[0] = 1'b0;
        if (cmd.data[5]) flag_next[1] = 1'b0;
        armed_next = cmd.data[3:2];
        // Timer A: a rising enable starts a stopped timer, a clear bit stops it
        if (cmd.data[0]) begin
          if (!enabled[0] && !running[0]) begin
            running_next[0] = 1'b1;
            ta_count_next   = ta_period;
          end
          enabled_next[0] = 1'b1;
        end else begin
          running_next[0] = 1'b0;
          enabled_next[0] = 1'b0;
        end
        // Timer B likewise
        if (cmd.data[1]) begin
          if (!enabled[1] && !running[1]) begin
            running_next[1] = 1'b1;
            tb_count_next   = tb_period;
          end
          enabled_next[1] = 1'b1;
        end else begin
          running_next[1] = 1'b0;
          enabled_next[1] = 1'b0;
        end
      end
      fmtif_pkg::TOP_TICK: begin
        // Count down; at the end flag an enabled, armed timer and reload
        if (running[0]) begin
          if (ta_count > fmtif_pkg::TA_CNT_W'(1)) begin
            ta_count_next = ta_count - fmtif_pkg::TA_CNT_W'(1);
          end else begin
            if (enabled[0] && armed[0]) begin
              armed_next[0] = 1'b0;
              flag_next[0]  = 1'b1;
            end
            ta_count_next = ta_period;
            expire_a      = 1'b1;
          end
        end
        if (running[1]) begin
          if (tb_count > fmtif_pkg::TB_CNT_W'(1)) begin
            tb_count_next = tb_count - fmtif_pkg::TB_CNT_W'(1);
          end else begin
            if (enabled[1] && armed[1]) begin
              armed_next[1] = 1'b0;
              flag_next[1]  = 1'b1;
            end
            tb_count_next = tb_period;
          end
        end
      end
      default: ;
    endcase
  end

  // Commit the timer state when a word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      ta_value <= '0;
      tb_value <= '0;
      enabled  <= '0;
      armed    <= '0;
      flag     <= '0;
      running  <= '0;
      ta_count <= '0;
      tb_count <= '0;
    end else if (fire) begin
      ta_value <= ta_value_next;
      tb_value <= tb_value_next;
      enabled  <= enabled_next;
      armed    <= armed_next;
      flag     <= flag_next;
      running  <= running_next;
      ta_count <= ta_count_next;
      tb_count <= tb_count_next;
    end
  end

  assign stat.flag      = flag;
  assign stat.flag_next = flag_next;
  assign stat.expire_a  = expire_a;

endmodule

// ===== rtl/fmtif_bus.sv =====
// Bus decoder: address latch, busy, status read, engine forwarding, port pins.
module fmtif_bus (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic [1:0]             mode,
  input  logic [1:0]             bus_addr,
  input  logic [7:0]             write_data,
  input  fmtif_pkg::timer_stat_t stat,
  output fmtif_pkg::timer_cmd_t  cmd,
  output fmtif_pkg::result_t     result
);

  logic [7:0] latched_address, latched_address_next;
  logic       busy, busy_next;
  logic       csm_enable, csm_enable_next;
  logic [1:0] port_pins, port_pins_next;

  // Decode the word and build its result
  always_comb begin
    latched_address_next = latched_address;
    busy_next            = busy;
    csm_enable_next      = csm_enable;
    port_pins_next       = port_pins;
    cmd.op               = fmtif_pkg::TOP_NONE;
    cmd.data             = write_data;
    result.read_data     = '0;
    result.engine_write  = 1'b0;
    result.engine_addr   = '0;
    result.engine_data   = '0;
    result.csm_pulse     = 1'b0;
    unique case (mode)
      fmtif_pkg::MODE_READ: begin
        result.read_data = fmtif_pkg::READ_FLOAT;
        if (bus_addr == fmtif_pkg::DATA_PORT) begin
          // Status: busy clears on read
          result.read_data = {busy, 5'b0, stat.flag[1], stat.flag[0]};
          busy_next        = 1'b0;
        end
      end
      fmtif_pkg::MODE_WRITE: begin
        if (bus_addr == fmtif_pkg::ADDR_PORT) begin
          latched_address_next = write_data;
          busy_next            = 1'b0;
        end else if (bus_addr == fmtif_pkg::DATA_PORT) begin
          busy_next = 1'b1;
          unique case (latched_address)
            fmtif_pkg::REG_TA_HI: cmd.op = fmtif_pkg::TOP_TA_HI;
            fmtif_pkg::REG_TA_LO: cmd.op = fmtif_pkg::TOP_TA_LO;
            fmtif_pkg::REG_TB:    cmd.op = fmtif_pkg::TOP_TB;
            fmtif_pkg::REG_CTRL: begin
              cmd.op              = fmtif_pkg::TOP_CTRL;
              csm_enable_next     = write_data[7];
              result.engine_write = 1'b1;
              result.engine_addr  = latched_address;
              result.engine_data  = write_data & fmtif_pkg::CTRL_FWD_MASK;
            end
            fmtif_pkg::REG_PINS: begin
              port_pins_next      = write_data[7:6];
              result.engine_write = 1'b1;
              result.engine_addr  = latched_address;
              result.engine_data  = write_data & fmtif_pkg::PINS_FWD_MASK;
            end
            default: begin
              result.engine_write = 1'b1;
              result.engine_addr  = latched_address;
              result.engine_data  = write_data;
            end
          endcase
        end
      end
      fmtif_pkg::MODE_TICK: begin
        cmd.op           = fmtif_pkg::TOP_TICK;
        result.csm_pulse = stat.expire_a & csm_enable;
      end
      fmtif_pkg::MODE_IDLE: ;
    endcase
    result.irq_n    = ~|stat.flag_next;
    result.port_ct1 = port_pins_next[1];
    result.port_ct2 = port_pins_next[0];
  end

  // Hold the bus state between words
  always_ff @(posedge clk) begin
    if (rst) begin
      latched_address <= '0;
      busy            <= 1'b0;
      csm_enable      <= 1'b0;
      port_pins       <= '0;
    end else if (fire) begin
      latched_address <= latched_address_next;
      busy            <= busy_next;
      csm_enable      <= csm_enable_next;
      port_pins       <= port_pins_next;
    end
  end

endmodule

// ===== rtl/fm_chip_bus_and_timer_interface.sv =====
// Top level of the FM chip bus and timer interface.
//
//   channel  dir  fields
//   item     in   mode, bus_addr, write_data
//   result   out  read_data, irq_n, port_ct1/2, engine_write/addr/data, csm_pulse
//
// One word a cycle unless the result is stalled: a word is registered at the
// input, then decoded and applied to the bus and timer state as its result
// is registered. Reset is synchronous; it clears the valid flags and all bus
// and timer state and stops both timers.
// A stalled result holds the input stage; a new word is still taken while
// the stalled result is handed over in the same cycle.
`include "fm_chip_bus_and_timer_interface_defines.svh"

module fm_chip_bus_and_timer_interface (
  input logic         clk,
  input logic         rst,
  fmtif_in_if.sink    item,
  fmtif_out_if.source result
);

  logic                   s1_valid;
  logic [1:0]             s1_mode;
  logic [1:0]             s1_addr;
  logic [7:0]             s1_data;
  logic                   advance;
  logic                   out_valid;
  fmtif_pkg::result_t     res_next;
  fmtif_pkg::result_t     res;
  fmtif_pkg::timer_cmd_t  cmd;
  fmtif_pkg::timer_stat_t stat;
  logic                   irq_in_step;
  logic                   engine_quiet;
  logic                   csm_clean;

  // Advance the input stage when the result register is free or draining
  assign advance    = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      s1_mode <= item.mode;
      s1_addr <= item.bus_addr;
      s1_data <= item.write_data;
    end
  end

  fmtif_bus u_bus (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .mode       (s1_mode),
    .bus_addr   (s1_addr),
    .write_data (s1_data),
    .stat       (stat),
    .cmd        (cmd),
    .result     (res_next)
  );

  fmtif_timers u_timers (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .cmd  (cmd),
    .stat (stat)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.read_data    = res.read_data;
  assign result.irq_n        = res.irq_n;
  assign result.port_ct1     = res.port_ct1;
  assign result.port_ct2     = res.port_ct2;
  assign result.engine_write = res.engine_write;
  assign result.engine_addr  = res.engine_addr;
  assign result.engine_data  = res.engine_data;
  assign result.csm_pulse    = res.csm_pulse;

  // Terms for the checks
  assign irq_in_step  = res.irq_n == !(|stat.flag);
  assign engine_quiet = res.engine_write ||
                        (res.engine_addr == 8'h00 && res.engine_data == 8'h00);
  assign csm_clean    = !res.csm_pulse || (!res.engine_write && res.read_data == 8'h00);

  // Checks
  `FMTIF_ASSERT_NXT(a_advance_fills, clk, rst, advance, out_valid, "result word lost")
  `FMTIF_ASSERT_IMP(a_irq_tracks_flags, clk, rst, out_valid, irq_in_step, "irq_n out of step")
  `FMTIF_ASSERT_IMP(a_engine_idle_zero, clk, rst, out_valid, engine_quiet, "stray engine fields")
  `FMTIF_ASSERT_IMP(a_csm_only_tick, clk, rst, out_valid, csm_clean, "csm pulse on a bus word")

endmodule

// ===== test/fm_chip_bus_and_timer_interface_checker.sv =====
// Checker for the bus and timer interface: predicts each result word and compares it.
`timescale 1ns / 100ps

module fm_chip_bus_and_timer_interface_checker
  import fmtif_pkg::*;
(
  input  logic clk,
  input  logic rst,
  fmtif_in_if  item,
  fmtif_out_if result,
  output int   errors,
  output int   pending
);

  // Timer indexes
  localparam int TMR_A = 0;
  localparam int TMR_B = 1;

  // Status byte bits
  localparam logic [7:0] STAT_BUSY   = 8'h80;
  localparam logic [7:0] STAT_FLAG_A = 8'h01;
  localparam logic [7:0] STAT_FLAG_B = 8'h02;

  // Control register bits
  localparam int CTRL_EN_A  = 0;
  localparam int CTRL_EN_B  = 1;
  localparam int CTRL_ARM_A = 2;
  localparam int CTRL_ARM_B = 3;
  localparam int CTRL_CLR_A = 4;
  localparam int CTRL_CLR_B = 5;
  localparam int CTRL_CSM   = 7;

  // Predicted chip state
  logic [7:0]  reg_sel;
  logic        busy;
  logic [9:0]  ta_val;
  logic [7:0]  tb_val;
  logic [1:0]  t_en;
  logic [1:0]  t_arm;
  logic [1:0]  t_flag;
  logic [1:0]  t_run;
  logic [15:0] ta_cnt;
  logic [17:0] tb_cnt;
  logic        csm_on;
  logic [1:0]  pins;

  result_t chip_outputs_due[$];
  int      mismatch_tally = 0;

  function automatic logic [15:0] ta_reload(input logic [9:0] v);
    return 16'((1024 - int'(v)) * 32);
  endfunction

  function automatic logic [17:0] tb_reload(input logic [7:0] v);
    return 18'((256 - int'(v)) * 512);
  endfunction

  // Load a stopped timer with its period and set it running
  function automatic void start_if_stopped(input int idx);
    if (!t_run[idx]) begin
      t_run[idx] = 1'b1;
      if (idx == TMR_A) ta_cnt = ta_reload(ta_val);
      else tb_cnt = tb_reload(tb_val);
    end
  endfunction

  // Rising enable starts a stopped timer; a clear bit stops and disables it
  function automatic void set_enable(input int idx, input logic on);
    if (on) begin
      if (!t_en[idx]) start_if_stopped(idx);
      t_en[idx] = 1'b1;
    end else begin
      t_run[idx] = 1'b0;
      t_en[idx]  = 1'b0;
    end
  endfunction

  function automatic void write_control(input logic [7:0] d);
    if (d[CTRL_CLR_A]) t_flag[TMR_A] = 1'b0;
    if (d[CTRL_CLR_B]) t_flag[TMR_B] = 1'b0;
    t_arm[TMR_A] = d[CTRL_ARM_A];
    set_enable(TMR_A, d[CTRL_EN_A]);
    t_arm[TMR_B] = d[CTRL_ARM_B];
    set_enable(TMR_B, d[CTRL_EN_B]);
    csm_on = d[CTRL_CSM];
  endfunction

  // Advance one timer by a tick; report expiry
  function automatic logic tick_timer(input int idx);
    logic [17:0] cnt;
    if (!t_run[idx]) return 1'b0;
    cnt = (idx == TMR_A) ? {2'b00, ta_cnt} : tb_cnt;
    if (cnt > 18'd1) begin
      cnt = cnt - 18'd1;
      if (idx == TMR_A) ta_cnt = cnt[15:0];
      else tb_cnt = cnt;
      return 1'b0;
    end
    if (t_en[idx] && t_arm[idx]) begin
      t_arm[idx]  = 1'b0;
      t_flag[idx] = 1'b1;
    end
    if (idx == TMR_A) ta_cnt = ta_reload(ta_val);
    else tb_cnt = tb_reload(tb_val);
    return 1'b1;
  endfunction

  // Apply one input word to the predicted state and build its result word
  function automatic result_t step_chip(input logic [1:0] m, input logic [1:0] a,
                                        input logic [7:0] d);
    result_t r;
    r = '0;
    case (m)
      MODE_READ: begin
        r.read_data = READ_FLOAT;
        if (a == DATA_PORT) begin
          r.read_data = '0;
          if (busy) begin
            r.read_data |= STAT_BUSY;
            busy = 1'b0;
          end
          if (t_flag[TMR_A]) r.read_data |= STAT_FLAG_A;
          if (t_flag[TMR_B]) r.read_data |= STAT_FLAG_B;
        end
      end
      MODE_WRITE: begin
        if (a == ADDR_PORT) begin
          reg_sel = d;
          busy    = 1'b0;
        end else if (a == DATA_PORT) begin
          case (reg_sel)
            REG_TA_HI: begin
              ta_val = {d, ta_val[1:0]};
              start_if_stopped(TMR_A);
            end
            REG_TA_LO: begin
              ta_val[1:0] = d[1:0];
              start_if_stopped(TMR_A);
            end
            REG_TB: begin
              tb_val = d;
              start_if_stopped(TMR_B);
            end
            default: begin
              r.engine_write = 1'b1;
              r.engine_addr  = reg_sel;
              r.engine_data  = d;
              if (reg_sel == REG_CTRL) begin
                write_control(d);
                r.engine_data = d & CTRL_FWD_MASK;
              end else if (reg_sel == REG_PINS) begin
                pins = d[7:6];
                r.engine_data = d & PINS_FWD_MASK;
              end
            end
          endcase
          busy = 1'b1;
        end
      end
      MODE_TICK: begin
        r.csm_pulse = tick_timer(TMR_A) && csm_on;
        void'(tick_timer(TMR_B));
      end
      default: ;
    endcase
    r.irq_n    = ~|t_flag;
    r.port_ct1 = pins[1];
    r.port_ct2 = pins[0];
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatch_tally++;
    end
  endtask

  // Retire result words against the oldest prediction, then predict new words
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      reg_sel = '0;
      busy    = 1'b0;
      ta_val  = '0;
      tb_val  = '0;
      t_en    = '0;
      t_arm   = '0;
      t_flag  = '0;
      t_run   = '0;
      ta_cnt  = '0;
      tb_cnt  = '0;
      csm_on  = 1'b0;
      pins    = '0;
      chip_outputs_due.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (chip_outputs_due.size() == 0) begin
          $display("%0t: result word expected none, got read_data 0x%0h engine_addr 0x%0h",
                   $time, result.read_data, result.engine_addr);
          mismatch_tally++;
        end else begin
          want = chip_outputs_due.pop_front();
          check_field("read_data", want.read_data, result.read_data);
          check_field("irq_n", want.irq_n, result.irq_n);
          check_field("port_ct1", want.port_ct1, result.port_ct1);
          check_field("port_ct2", want.port_ct2, result.port_ct2);
          check_field("engine_write", want.engine_write, result.engine_write);
          check_field("engine_addr", want.engine_addr, result.engine_addr);
          check_field("engine_data", want.engine_data, result.engine_data);
          check_field("csm_pulse", want.csm_pulse, result.csm_pulse);
        end
      end
      if (item.valid && item.ready)
        chip_outputs_due.push_back(step_chip(item.mode, item.bus_addr, item.write_data));
    end
    errors  <= mismatch_tally;
    pending <= chip_outputs_due.size();
  end

endmodule

// ===== test/fm_chip_bus_and_timer_interface_tb.sv =====
// Testbench top for the bus and timer interface: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module fm_chip_bus_and_timer_interface_tb;
  import fmtif_pkg::*;

  localparam int PHASE_WORDS    = 180;
  localparam int LONG_RUN_PHASE = 3;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int SETTLE_CYCLES  = 8;

  logic clk;
  logic rst;
  int   src_idle_pct   = 0;
  int   sink_stall_pct = 0;
  int   words_sent     = 0;
  int   errors;
  int   pending;

  int idle_by_phase[4]  = '{0, 51, 0, 26};
  int stall_by_phase[4] = '{0, 0, 51, 26};

  fmtif_in_if  in_ch ();
  fmtif_out_if out_ch ();

  fm_chip_bus_and_timer_interface dut (
    .clk    (clk),
    .rst    (rst),
    .item   (in_ch),
    .result (out_ch)
  );

  fm_chip_bus_and_timer_interface_checker chk (
    .clk     (clk),
    .rst     (rst),
    .item    (in_ch),
    .result  (out_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at random
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Hard stop if the run hangs
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("fm_chip_bus_and_timer_interface_tb failed");
    $finish;
  end

  // Offer one word, with random idle cycles ahead of it, and hold until taken
  task automatic send_word(input logic [1:0] m, input logic [1:0] a, input logic [7:0] d);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= m;
    in_ch.bus_addr   <= a;
    in_ch.write_data <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic write_reg(input logic [7:0] r, input logic [7:0] d);
    send_word(MODE_WRITE, ADDR_PORT, r);
    send_word(MODE_WRITE, DATA_PORT, d);
  endtask

  task automatic tick_run(input int n);
    repeat (n) send_word(MODE_TICK, 2'($urandom), 8'($urandom));
  endtask

  // Drop valid and wait for every predicted word to come back
  task automatic await_all_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One well-formed access sequence with random content, or a noise word
  task automatic random_sequence();
    int         pick;
    logic [7:0] d;
    pick = $urandom_range(99);
    d    = 8'($urandom);
    if (pick < 40) begin
      tick_run($urandom_range(1, 24));
    end else if (pick < 52) begin
      send_word(MODE_READ, DATA_PORT, d);
    end else if (pick < 55) begin
      // keep timer A short most of the time
      write_reg(REG_TA_HI, ($urandom_range(4) == 0) ? d : {6'h3F, d[1:0]});
    end else if (pick < 57) begin
      write_reg(REG_TA_LO, d);
    end else if (pick < 60) begin
      write_reg(REG_TB, ($urandom_range(5) == 0) ? d : {7'h7F, d[0]});
    end else if (pick < 72) begin
      // favour enabled timers so that they live long enough to expire
      if ($urandom_range(3) != 0) d[0] = 1'b1;
      if ($urandom_range(7) != 0) d[1] = 1'b1;
      write_reg(REG_CTRL, d);
    end else if (pick < 80) begin
      write_reg(REG_PINS, d);
    end else if (pick < 88) begin
      write_reg(8'($urandom), d);
    end else if (pick < 94) begin
      send_word(MODE_WRITE, DATA_PORT, d);
    end else begin
      send_word(2'($urandom), 2'($urandom), d);
    end
  endtask

  initial begin
    int phase_start;
    rst              <= 1'b1;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= MODE_IDLE;
    in_ch.bus_addr   <= '0;
    in_ch.write_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every port on read, ignored writes, idle word, busy, masks, timers
    send_word(MODE_READ, 2'd0, 8'h00);
    send_word(MODE_READ, ADDR_PORT, 8'hFF);
    send_word(MODE_READ, 2'd2, 8'h00);
    send_word(MODE_READ, DATA_PORT, 8'hFF);
    send_word(MODE_WRITE, 2'd0, 8'hFF);
    send_word(MODE_WRITE, 2'd2, 8'h00);
    send_word(MODE_IDLE, DATA_PORT, 8'hFF);
    write_reg(REG_PINS, 8'hC0);
    send_word(MODE_READ, DATA_PORT, 8'h00);
    send_word(MODE_READ, DATA_PORT, 8'h00);
    write_reg(REG_PINS, 8'h3F);
    write_reg(8'hFF, 8'hA5);
    write_reg(8'h00, 8'h00);
    write_reg(REG_TA_HI, 8'hFF);
    write_reg(REG_TA_LO, 8'h03);
    write_reg(REG_TB, 8'hFF);
    write_reg(REG_CTRL, 8'hBF);
    send_word(MODE_WRITE, DATA_PORT, 8'h8F);

    // Random phases with differing idle and stall rates
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = idle_by_phase[ph];
      sink_stall_pct = stall_by_phase[ph];
      if (ph == LONG_RUN_PHASE) begin
        // hold off until drained, then run timer B to expiry from a clean start
        await_all_results();
        write_reg(REG_TB, 8'hFF);
        write_reg(REG_CTRL, 8'h3C);
        write_reg(REG_CTRL, 8'h8F);
        tick_run(530);
        send_word(MODE_READ, DATA_PORT, 8'h00);
        write_reg(REG_CTRL, 8'h33);
      end
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) random_sequence();
    end

    await_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("fm_chip_bus_and_timer_interface_tb passed");
    else
      $display("fm_chip_bus_and_timer_interface_tb failed");
    $finish;
  end

endmodule
